// ----- hdl/pce_pkg.sv -----
package pce_pkg;

    localparam int PRIO_W = 8;
    localparam int OWN_W  = 8;
    localparam int MODE_W = 3;
    localparam int TASK_W = 5;
    localparam int ADDR_W = 32;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    localparam int RES_COUNT = 64;
    localparam int RES_IDX_W = $clog2(RES_COUNT);
    localparam int ADDR_LSB  = 2;

    localparam int DEF_NUM_TASKS       = 32;
    localparam int DEF_PRIORITY_LEVELS = 256;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET_CEILING = 3'd0,
        MODE_GET_CEILING = 3'd1,
        MODE_ENTER       = 3'd2,
        MODE_EXIT        = 3'd3,
        MODE_SET_BASE    = 3'd4,
        MODE_BOOST       = 3'd5,
        MODE_RESTORE     = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_VIOLATED  = 2'd3
    } t_status;

    typedef struct packed {
        logic [PRIO_W-1:0] ceiling;
        logic [OWN_W-1:0]  owner;
    } t_res_entry;

    typedef struct packed {
        logic [PRIO_W-1:0] base;
        logic [PRIO_W-1:0] eff;
    } t_task_entry;

    typedef struct packed {
        t_mode             mode;
        logic              task_ok;
        logic              prio_ok;
        logic              addr_zero;
        logic [PRIO_W-1:0] prio;
        logic              in_use;
        t_res_entry        res;
        t_task_entry       tsk;
    } t_op_in;

    typedef struct packed {
        t_status           status;
        logic [PRIO_W-1:0] prio_out;
        logic              res_we;
        t_res_entry        res_wdata;
        logic              task_we;
        t_task_entry       task_wdata;
    } t_op_out;

endpackage

// ----- hdl/pce_ram.sv -----
module pce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/pce_ops.sv -----
module pce_ops
    import pce_pkg::*;
(
    input  t_op_in  i_op,
    output t_op_out o_op
);

    logic [PRIO_W-1:0] ceil;
    logic [OWN_W-1:0]  own;
    logic [PRIO_W-1:0] n_base;
    logic [PRIO_W-1:0] n_eff;
    logic [OWN_W-1:0]  n_own;
    logic [PRIO_W-1:0] get_val;
    t_status           status;
    logic              res_we;
    logic              task_we;

    always_comb begin
        ceil    = i_op.in_use ? i_op.res.ceiling : '0;
        own     = i_op.in_use ? i_op.res.owner : '0;
        n_base  = i_op.tsk.base;
        n_eff   = i_op.tsk.eff;
        n_own   = own;
        get_val = '0;
        status  = ST_OK;
        res_we  = 1'b0;
        task_we = 1'b0;

        case (i_op.mode)
            MODE_SET_CEILING: begin
                if (i_op.addr_zero || !i_op.prio_ok) begin
                    status = ST_INVALID;
                end else begin
                    ceil   = i_op.prio;
                    res_we = 1'b1;
                end
            end
            MODE_GET_CEILING: begin
                if (i_op.addr_zero) begin
                    status = ST_INVALID;
                end else begin
                    get_val = ceil;
                end
            end
            MODE_ENTER: begin
                if (!i_op.task_ok || i_op.addr_zero) begin
                    status = ST_INVALID;
                end else if (!i_op.in_use) begin
                    status = ST_NOT_FOUND;
                end else if (i_op.tsk.base > ceil) begin
                    status = ST_VIOLATED;
                end else begin
                    if (i_op.tsk.eff < ceil) begin
                        n_eff = ceil;
                    end
                    if (own != '1) begin
                        n_own = own + OWN_W'(1);
                    end
                    res_we  = 1'b1;
                    task_we = 1'b1;
                end
            end
            MODE_EXIT: begin
                if (!i_op.task_ok || i_op.addr_zero) begin
                    status = ST_INVALID;
                end else if (own != '0) begin
                    n_own  = own - OWN_W'(1);
                    res_we = 1'b1;
                    if (n_own == '0) begin
                        n_eff   = i_op.tsk.base;
                        task_we = 1'b1;
                    end
                end
            end
            MODE_SET_BASE: begin
                if (!i_op.task_ok || !i_op.prio_ok) begin
                    status = ST_INVALID;
                end else begin
                    n_base = i_op.prio;
                    if (i_op.tsk.eff == i_op.tsk.base) begin
                        n_eff = i_op.prio;
                    end
                    task_we = 1'b1;
                end
            end
            MODE_BOOST: begin
                if (!i_op.task_ok || !i_op.prio_ok) begin
                    status = ST_INVALID;
                end else if (i_op.prio > i_op.tsk.eff) begin
                    n_eff   = i_op.prio;
                    task_we = 1'b1;
                end
            end
            MODE_RESTORE: begin
                if (!i_op.task_ok) begin
                    status = ST_INVALID;
                end else begin
                    n_eff   = i_op.tsk.base;
                    task_we = 1'b1;
                end
            end
            default: begin
                status = ST_INVALID;
            end
        endcase

        o_op.status             = status;
        o_op.res_we             = res_we;
        o_op.res_wdata.ceiling  = ceil;
        o_op.res_wdata.owner    = n_own;
        o_op.task_we            = task_we;
        o_op.task_wdata.base    = n_base;
        o_op.task_wdata.eff     = n_eff;
        if (i_op.mode == MODE_GET_CEILING) begin
            o_op.prio_out = get_val;
        end else begin
            o_op.prio_out = i_op.task_ok ? n_eff : '0;
        end
    end

endmodule

// ----- hdl/priority_ceiling_engine.sv -----
// Priority-ceiling resource manager.
// The slave stream carries one operation per word: tuser holds the mode,
// tdata holds the task index, the resource address and a priority. The
// master stream returns one word per operation with a status code and a
// priority (the ceiling for a get, else the task's effective priority).
// A word is taken when tvalid and tready are both high.
// One word can be accepted in every cycle unless the master side stalls:
// the resource and task tables are RAMs with a registered read, so each
// operation passes through the read stage and then a read-modify-write
// into the result register, with write data forwarded to a following
// operation on the same entry.
// A synchronous active-low reset empties both stages and clears the
// per-entry valid bits, so all ceilings, owner counts and priorities read as
// zero afterward; there is no clearing pass.
// When the receiver holds tready low, the result word stays on the master
// port, one more word waits in the read stage, and then the slave tready
// drops until the result is taken.
module priority_ceiling_engine
    import pce_pkg::*;
#(
    parameter int NUM_TASKS       = DEF_NUM_TASKS,
    parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // Fields from bit 0: task_index[4:0], resource_addr[36:5],
    // priority_value[44:37], zero padding.
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // Fields from bit 0: mode[2:0].
    input  logic [MODE_W-1:0]     i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // Fields from bit 0: status[1:0], priority_out[9:2], zero padding.
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int TIDX_W = $clog2(NUM_TASKS);

    logic                 s_acc;
    logic                 s1_adv;
    logic [TASK_W-1:0]    in_task;
    logic [ADDR_W-1:0]    in_addr;
    logic [PRIO_W-1:0]    in_prio;
    logic [RES_IDX_W-1:0] in_slot;
    logic [TIDX_W-1:0]    in_tidx;

    logic                 r_s1_valid;
    t_mode                r_mode;
    logic                 r_task_ok;
    logic                 r_prio_ok;
    logic                 r_addr_zero;
    logic [PRIO_W-1:0]    r_prio;
    logic [RES_IDX_W-1:0] r_slot;
    logic [TIDX_W-1:0]    r_tidx;
    logic                 r_res_hit;
    t_res_entry           r_res_fwd;
    logic                 r_task_hit;
    t_task_entry          r_task_fwd;

    logic [RES_COUNT-1:0] r_in_use;
    logic [NUM_TASKS-1:0] r_task_valid;

    logic                 r_out_valid;
    t_status              r_status;
    logic [PRIO_W-1:0]    r_prio_out;

    t_res_entry           res_rdata;
    t_task_entry          task_rdata;
    t_op_in               op_in;
    t_op_out              op_out;
    logic                 res_we;
    logic                 task_we;

    assign in_task = i_s_axis_tdata[TASK_W-1:0];
    assign in_addr = i_s_axis_tdata[TASK_W+ADDR_W-1:TASK_W];
    assign in_prio = i_s_axis_tdata[TASK_W+ADDR_W+PRIO_W-1:TASK_W+ADDR_W];
    assign in_slot = in_addr[RES_IDX_W+ADDR_LSB-1:ADDR_LSB];
    assign in_tidx = TIDX_W'(in_task);

    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign res_we          = s1_adv && op_out.res_we;
    assign task_we         = s1_adv && op_out.task_we;

    pce_ram #(
        .WIDTH($bits(t_res_entry)),
        .DEPTH(RES_COUNT)
    ) u_res_ram (
        .i_clk  (i_clk),
        .i_we   (res_we),
        .i_waddr(r_slot),
        .i_wdata(op_out.res_wdata),
        .i_re   (s_acc),
        .i_raddr(in_slot),
        .o_rdata(res_rdata)
    );

    pce_ram #(
        .WIDTH($bits(t_task_entry)),
        .DEPTH(NUM_TASKS)
    ) u_task_ram (
        .i_clk  (i_clk),
        .i_we   (task_we),
        .i_waddr(r_tidx),
        .i_wdata(op_out.task_wdata),
        .i_re   (s_acc),
        .i_raddr(in_tidx),
        .o_rdata(task_rdata)
    );

    always_comb begin
        op_in.mode      = r_mode;
        op_in.task_ok   = r_task_ok;
        op_in.prio_ok   = r_prio_ok;
        op_in.addr_zero = r_addr_zero;
        op_in.prio      = r_prio;
        op_in.in_use    = r_in_use[r_slot];
        if (r_in_use[r_slot]) begin
            op_in.res = r_res_hit ? r_res_fwd : res_rdata;
        end else begin
            op_in.res = '0;
        end
        if (r_task_ok && r_task_valid[r_tidx]) begin
            op_in.tsk = r_task_hit ? r_task_fwd : task_rdata;
        end else begin
            op_in.tsk = '0;
        end
    end

    pce_ops u_ops (
        .i_op(op_in),
        .o_op(op_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_in_use     <= '0;
            r_task_valid <= '0;
        end else begin
            if (s_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (res_we) begin
                r_in_use[r_slot] <= 1'b1;
            end
            if (task_we) begin
                r_task_valid[r_tidx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mode      <= t_mode'(i_s_axis_tuser);
            r_task_ok   <= 32'(in_task) < NUM_TASKS;
            r_prio_ok   <= 32'(in_prio) < PRIORITY_LEVELS;
            r_addr_zero <= in_addr == '0;
            r_prio      <= in_prio;
            r_slot      <= in_slot;
            r_tidx      <= in_tidx;
            r_res_hit   <= res_we && (r_slot == in_slot);
            r_res_fwd   <= op_out.res_wdata;
            r_task_hit  <= task_we && (r_tidx == in_tidx);
            r_task_fwd  <= op_out.task_wdata;
        end
        if (s1_adv) begin
            r_status   <= op_out.status;
            r_prio_out <= op_out.prio_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - PRIO_W - 2)'(0), r_prio_out, r_status};

endmodule

// ----- hdl/pce_checker.sv -----
module pce_checker
    import pce_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic s_acc;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("Output word dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("Output word changed while stalled.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("Input stalled with an empty output register.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc ##1 i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("Accepted word did not reach the output in two cycles.");

endmodule

bind priority_ceiling_engine pce_checker u_pce_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata)
);

// ----- bench/tb_priority_ceiling_engine.sv -----
module tb_priority_ceiling_engine;
    import pce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int TARGET_OPS  = 1550;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        t_status           status;
        logic [PRIO_W-1:0] prio;
    } t_reply;

    class ceiling_scoreboard;
        bit [PRIO_W-1:0] ceiling [RES_COUNT];
        bit              in_use [RES_COUNT];
        bit [OWN_W-1:0]  owners [RES_COUNT];
        bit [PRIO_W-1:0] base_prio [DEF_NUM_TASKS];
        bit [PRIO_W-1:0] eff_prio [DEF_NUM_TASKS];
        t_reply          pending_replies [$];
        int              failures;

        function void note_request(input logic [MODE_W-1:0] mode,
                                   input logic [TASK_W-1:0] tsk,
                                   input logic [ADDR_W-1:0] addr,
                                   input logic [PRIO_W-1:0] prio);
            t_reply          r;
            bit              task_ok;
            bit              prio_ok;
            bit              addr_zero;
            bit              report_eff;
            bit [PRIO_W-1:0] old_base;
            int              slot;
            task_ok    = tsk < DEF_NUM_TASKS;
            prio_ok    = prio < DEF_PRIORITY_LEVELS;
            addr_zero  = addr == '0;
            slot       = int'(addr[ADDR_LSB +: RES_IDX_W]);
            r.status   = ST_OK;
            r.prio     = '0;
            report_eff = 1'b1;
            case (mode)
                MODE_SET_CEILING: begin
                    if (addr_zero || !prio_ok) begin
                        r.status = ST_INVALID;
                    end else begin
                        ceiling[slot] = prio;
                        in_use[slot]  = 1'b1;
                    end
                end
                MODE_GET_CEILING: begin
                    report_eff = 1'b0;
                    if (addr_zero) begin
                        r.status = ST_INVALID;
                    end else if (in_use[slot]) begin
                        r.prio = ceiling[slot];
                    end
                end
                MODE_ENTER: begin
                    if (!task_ok || addr_zero) begin
                        r.status = ST_INVALID;
                    end else if (!in_use[slot]) begin
                        r.status = ST_NOT_FOUND;
                    end else if (base_prio[tsk] > ceiling[slot]) begin
                        r.status = ST_VIOLATED;
                    end else begin
                        if (eff_prio[tsk] < ceiling[slot]) eff_prio[tsk] = ceiling[slot];
                        if (owners[slot] != '1) owners[slot]++;
                    end
                end
                MODE_EXIT: begin
                    if (!task_ok || addr_zero) begin
                        r.status = ST_INVALID;
                    end else if (owners[slot] > 0) begin
                        owners[slot]--;
                        if (owners[slot] == 0) eff_prio[tsk] = base_prio[tsk];
                    end
                end
                MODE_SET_BASE: begin
                    if (!task_ok || !prio_ok) begin
                        r.status = ST_INVALID;
                    end else begin
                        old_base       = base_prio[tsk];
                        base_prio[tsk] = prio;
                        if (eff_prio[tsk] == old_base) eff_prio[tsk] = prio;
                    end
                end
                MODE_BOOST: begin
                    if (!task_ok || !prio_ok) begin
                        r.status = ST_INVALID;
                    end else if (prio > eff_prio[tsk]) begin
                        eff_prio[tsk] = prio;
                    end
                end
                MODE_RESTORE: begin
                    if (!task_ok) r.status = ST_INVALID;
                    else eff_prio[tsk] = base_prio[tsk];
                end
                default: begin
                    r.status = ST_INVALID;
                end
            endcase
            if (report_eff) r.prio = task_ok ? eff_prio[tsk] : '0;
            pending_replies.push_back(r);
        endfunction

        function void check_reply(input logic [OUT_DATA_W-1:0] word);
            t_reply exp_r;
            if (pending_replies.size() == 0) begin
                $error("result word %h arrived with no operation outstanding", word);
                failures++;
                return;
            end
            exp_r = pending_replies.pop_front();
            if (word[1:0] !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, word[1:0]);
                failures++;
            end
            if (word[9:2] !== exp_r.prio) begin
                $error("priority_out: expected %0d, got %0d", exp_r.prio, word[9:2]);
                failures++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // Fields from bit 0: task_index, resource_addr, priority_value, zero padding.
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // Fields from bit 0: mode.
    logic [MODE_W-1:0]     i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // Fields from bit 0: status, priority_out, zero padding.
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    ceiling_scoreboard sb = new();
    bit calm = 1'b0;
    int ops_sent = 0;
    int stall_request = 0;
    int stalls_served = 0;
    int hold_left = 0;

    priority_ceiling_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            sb.check_reply(o_m_axis_tdata);
        end
        if (stall_request != stalls_served) begin
            stalls_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= calm || ($urandom_range(99) >= 6);
        end
    end

    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [TASK_W-1:0] tsk,
                           input logic [ADDR_W-1:0] addr, input logic [PRIO_W-1:0] prio);
        while (!calm && $urandom_range(99) < 6) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= mode;
        i_s_axis_tdata  <= {3'b000, prio, addr, tsk};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        sb.note_request(mode, tsk, addr, prio);
        ops_sent++;
        if (ops_sent == 300 || ops_sent == 1200) stall_request++;
        calm = ops_sent >= 650 && ops_sent < 950;
    endtask

    function automatic logic [ADDR_W-1:0] slot_addr(input int slot);
        logic [ADDR_W-1:0] a;
        a = {24'($urandom()), 8'h00};
        a[ADDR_LSB +: RES_IDX_W] = RES_IDX_W'(slot);
        a[1:0] = 2'($urandom_range(3));
        if (a == '0) a[ADDR_W-1] = 1'b1;
        return a;
    endfunction

    task automatic run_ceiling_session();
        int              tsk;
        int              slot;
        int              nest;
        int              extra;
        logic [PRIO_W-1:0] ceil_val;
        tsk  = $urandom_range(31);
        slot = $urandom_range(15);
        ceil_val = 8'hFF;
        if ($urandom_range(99) < 80) begin
            ceil_val = PRIO_W'($urandom());
            send_op(MODE_SET_CEILING, TASK_W'(tsk), slot_addr(slot), ceil_val);
        end
        if ($urandom_range(99) < 60) begin
            if ($urandom_range(99) < 85) send_op(MODE_SET_BASE, TASK_W'(tsk), slot_addr(slot),
                                                 PRIO_W'($urandom_range(ceil_val)));
            else send_op(MODE_SET_BASE, TASK_W'(tsk), slot_addr(slot), PRIO_W'($urandom()));
        end
        nest = $urandom_range(1, 3);
        for (int i = 0; i < nest; i++) begin
            send_op(MODE_ENTER, TASK_W'(tsk), slot_addr(slot), PRIO_W'($urandom()));
        end
        extra = $urandom_range(2);
        for (int i = 0; i < extra; i++) begin
            send_op(MODE_W'($urandom_range(6)), TASK_W'(tsk),
                    slot_addr($urandom_range(15)), PRIO_W'($urandom()));
        end
        nest += $urandom_range(1);
        for (int i = 0; i < nest; i++) begin
            send_op(MODE_EXIT, TASK_W'(tsk), slot_addr(slot), PRIO_W'($urandom()));
        end
        if ($urandom_range(99) < 30) begin
            send_op(MODE_RESTORE, TASK_W'(tsk), slot_addr(slot), PRIO_W'($urandom()));
        end
    endtask

    task automatic run_stray_op();
        logic [ADDR_W-1:0] addr;
        addr = ($urandom_range(9) == 0) ? '0 : $urandom();
        send_op(MODE_W'($urandom_range(7)), TASK_W'($urandom()), addr, PRIO_W'($urandom()));
    endtask

    initial begin
        int tsk;
        int slot;
        logic [PRIO_W-1:0] ceil_val;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(MODE_GET_CEILING, 5'd3, 32'h0000_0004, 8'h00);
        send_op(MODE_SET_CEILING, 5'd3, 32'h0000_0000, 8'h20);
        send_op(MODE_GET_CEILING, 5'd3, 32'h0000_0000, 8'hFF);
        send_op(MODE_ENTER, 5'd3, 32'h0000_0010, 8'h00);
        send_op(MODE_SET_CEILING, 5'd0, 32'hFFFF_FF07, 8'hFF);
        send_op(MODE_SET_CEILING, 5'd0, 32'h0000_0008, 8'h00);
        send_op(MODE_SET_BASE, 5'd31, 32'hFFFF_FFFF, 8'hFF);
        send_op(MODE_ENTER, 5'd31, 32'h0000_0008, 8'h00);
        send_op(MODE_SET_BASE, 5'd0, 32'h0000_0001, 8'd10);
        send_op(MODE_ENTER, 5'd0, 32'h0000_0004, 8'h00);
        send_op(MODE_ENTER, 5'd0, 32'h8000_0005, 8'h00);
        send_op(MODE_EXIT, 5'd0, 32'h0000_0006, 8'h00);
        send_op(MODE_EXIT, 5'd0, 32'h0000_0004, 8'h00);
        send_op(MODE_EXIT, 5'd0, 32'h0000_0004, 8'h00);
        send_op(MODE_EXIT, 5'd0, 32'h0000_0000, 8'h00);
        send_op(MODE_ENTER, 5'd0, 32'h0000_0000, 8'h00);
        send_op(MODE_BOOST, 5'd5, 32'h0000_0000, 8'd200);
        send_op(MODE_BOOST, 5'd5, 32'h0000_0000, 8'd100);
        send_op(MODE_SET_BASE, 5'd5, 32'h0000_0000, 8'd50);
        send_op(MODE_RESTORE, 5'd5, 32'h0000_0000, 8'hFF);
        send_op(MODE_UNUSED, 5'd5, 32'hFFFF_FFFF, 8'hFF);
        send_op(MODE_GET_CEILING, 5'd0, 32'h1234_5604, 8'h00);
        send_op(MODE_SET_BASE, 5'd31, 32'h0000_0000, 8'h00);
        send_op(MODE_SET_CEILING, 5'd31, 32'hFFFF_FFFF, 8'd128);

        // Drive one resource past a full owner count, then drain it.
        tsk  = $urandom_range(31);
        slot = $urandom_range(16, 63);
        ceil_val = PRIO_W'($urandom_range(1, 255));
        send_op(MODE_SET_CEILING, TASK_W'(tsk), slot_addr(slot), ceil_val);
        send_op(MODE_SET_BASE, TASK_W'(tsk), slot_addr(slot),
                PRIO_W'($urandom_range(ceil_val)));
        repeat (258) send_op(MODE_ENTER, TASK_W'(tsk), slot_addr(slot), PRIO_W'($urandom()));
        repeat (256) send_op(MODE_EXIT, TASK_W'(tsk), slot_addr(slot), PRIO_W'($urandom()));

        while (ops_sent < TARGET_OPS) begin
            if ($urandom_range(99) < 75) run_ceiling_session();
            else run_stray_op();
        end
        i_s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (sb.pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #400us;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/pce_pkg.sv
hdl/pce_ram.sv
hdl/pce_ops.sv
hdl/priority_ceiling_engine.sv
hdl/pce_checker.sv
bench/tb_priority_ceiling_engine.sv
